>>> hw/rtl/three_axis_offset_moving_average_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis offset moving average block.
// Each macro expands to one labeled concurrent assertion on clk_i, which is
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_OFFSET_MOVING_AVERAGE_ASSERT_SVH
`define THREE_AXIS_OFFSET_MOVING_AVERAGE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAMAVG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TAMAVG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tamavg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamavg_pkg
// Shared constants, widths and types of the three-axis offset moving average.
// ----------------------------------------------------------------------------
package tamavg_pkg;

  localparam int AXES             = 3;
  localparam int SAMPLE_W         = 16;
  localparam int ACCEL_W          = 23;
  localparam int FILTER_TAPS      = 10;
  localparam int CAL_COUNT        = 100;
  localparam int G_SCALE_TENTH_MG = 78;

  // Boxcar sum: magnitude bound is FILTER_TAPS * 2^15.
  localparam int TAP_MAG_W     = SAMPLE_W + $clog2(FILTER_TAPS);
  localparam int TAP_SUM_W     = TAP_MAG_W + 1;
  localparam int TAP_DIV_SHIFT = TAP_MAG_W + $clog2(FILTER_TAPS) + 1;
  localparam int TAP_RECIP_W   = TAP_DIV_SHIFT + 1;
  localparam int TAP_PROD_W    = TAP_MAG_W + TAP_RECIP_W;
  localparam logic [TAP_RECIP_W-1:0] TAP_RECIP = TAP_RECIP_W'(
    ((64'd1 << TAP_DIV_SHIFT) + 64'(FILTER_TAPS - 1)) / 64'(FILTER_TAPS));

  // Calibration sum: magnitude bound is CAL_COUNT * 2^15.
  localparam int CAL_MAG_W     = SAMPLE_W + $clog2(CAL_COUNT);
  localparam int CAL_SUM_W     = CAL_MAG_W + 1;
  localparam int CAL_DIV_SHIFT = CAL_MAG_W + $clog2(CAL_COUNT);
  localparam int CAL_RECIP_W   = CAL_DIV_SHIFT + 1;
  localparam int CAL_PROD_W    = CAL_MAG_W + CAL_RECIP_W;
  localparam logic [CAL_RECIP_W-1:0] CAL_RECIP = CAL_RECIP_W'(
    ((64'd1 << CAL_DIV_SHIFT) + 64'(CAL_COUNT - 1)) / 64'(CAL_COUNT));

  localparam int CNT_W = $clog2(CAL_COUNT + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef sample_t [AXES-1:0]         axes_t;
  typedef logic signed [ACCEL_W-1:0]  accel_t;

  // Control flags handed from the averaging pipeline to the calibration unit.
  typedef struct packed {
    logic fire;
    logic cal;
    logic done;
  } cal_ctl_t;

endpackage

>>> hw/rtl/tamavg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamavg_in_if
// Sample channel: one raw three-axis sample and its calibrate flag.
// ----------------------------------------------------------------------------
interface tamavg_in_if;
  import tamavg_pkg::*;

  logic    valid;
  logic    ready;
  sample_t raw_x;
  sample_t raw_y;
  sample_t raw_z;
  logic    calibrate;

  modport source (output valid, output raw_x, output raw_y, output raw_z,
                  output calibrate, input ready);
  modport sink (input valid, input raw_x, input raw_y, input raw_z,
                input calibrate, output ready);
endinterface

>>> hw/rtl/tamavg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamavg_out_if
// Result channel: filtered counts, acceleration and the calibration flag.
// ----------------------------------------------------------------------------
interface tamavg_out_if;
  import tamavg_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered_x;
  sample_t filtered_y;
  sample_t filtered_z;
  accel_t  accel_x;
  accel_t  accel_y;
  accel_t  accel_z;
  logic    calibration_done;

  modport source (output valid, output filtered_x, output filtered_y,
                  output filtered_z, output accel_x, output accel_y,
                  output accel_z, output calibration_done, input ready);
  modport sink (input valid, input filtered_x, input filtered_y,
                input filtered_z, input accel_x, input accel_y,
                input accel_z, input calibration_done, output ready);
endinterface

>>> hw/rtl/tamavg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamavg_cell
// One tap of the boxcar delay line, holding one sample of each axis.
// ----------------------------------------------------------------------------
module tamavg_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_i,
  input  tamavg_pkg::axes_t tap_i,
  output tamavg_pkg::axes_t tap_o
);
  import tamavg_pkg::*;

  axes_t tap_q;

  // History starts at zero, so the cell is cleared on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= tap_i;
    end
  end

  assign tap_o = tap_q;
endmodule

>>> hw/rtl/tamavg_cal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tamavg_cal
// Calibration sums and the offset update, which divides each sum by the
// calibration count in three steps: magnitude, reciprocal multiply, sign.
// ----------------------------------------------------------------------------
module tamavg_cal (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tamavg_pkg::cal_ctl_t ctl_i,
  input  tamavg_pkg::axes_t    filt_i,
  output tamavg_pkg::axes_t    offset_o,
  output logic                 upd_o
);
  import tamavg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABS,
    ST_MUL,
    ST_SIGN
  } state_e;

  state_e                      state_q;
  logic signed [CAL_SUM_W-1:0] sum_q [AXES];
  logic        [CAL_MAG_W-1:0] mag_q [AXES];
  logic        [SAMPLE_W-1:0]  quo_q [AXES];
  logic        [AXES-1:0]      neg_q;
  axes_t                       offset_q;
  logic                        upd_q;
  logic        [CAL_PROD_W-1:0] prod [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prod[a] = CAL_PROD_W'(mag_q[a]) * CAL_PROD_W'(CAL_RECIP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      offset_q <= '0;
      upd_q    <= 1'b0;
      neg_q    <= '0;
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
        mag_q[a] <= '0;
        quo_q[a] <= '0;
      end
    end else begin
      upd_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (ctl_i.fire && ctl_i.cal) begin
            for (int a = 0; a < AXES; a++) begin
              sum_q[a] <= sum_q[a] + CAL_SUM_W'(filt_i[a]);
            end
            if (ctl_i.done) begin
              state_q <= ST_ABS;
            end
          end
        end
        ST_ABS: begin
          // The sums are taken apart and cleared for the next calibration.
          for (int a = 0; a < AXES; a++) begin
            neg_q[a] <= sum_q[a][CAL_SUM_W-1];
            mag_q[a] <= sum_q[a][CAL_SUM_W-1] ? CAL_MAG_W'(-sum_q[a])
                                              : CAL_MAG_W'(sum_q[a]);
            sum_q[a] <= '0;
          end
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          for (int a = 0; a < AXES; a++) begin
            quo_q[a] <= prod[a][CAL_DIV_SHIFT +: SAMPLE_W];
          end
          state_q <= ST_SIGN;
        end
        ST_SIGN: begin
          for (int a = 0; a < AXES; a++) begin
            offset_q[a] <= neg_q[a] ? -sample_t'(quo_q[a]) : sample_t'(quo_q[a]);
          end
          upd_q   <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign offset_o = offset_q;
  assign upd_o    = upd_q;
endmodule

>>> hw/rtl/three_axis_offset_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_offset_moving_average
// Offset correction, boxcar averaging and offset calibration of a three-axis
// accelerometer sample stream.
// ----------------------------------------------------------------------------
// The block takes one sample transfer per clock while the output is not
// stalled and returns one result transfer per sample. Each axis has its
// offset subtracted (16-bit wrap), enters a delay line of FILTER_TAPS cells
// and a running sum, and the sum is divided by FILTER_TAPS (toward zero)
// with a reciprocal multiply. The acceleration output is the filtered
// value times 78, in units of 0.1 milli-g. Samples flagged with calibrate
// add their filtered value to per-axis sums; the sample that completes
// CAL_COUNT such samples carries calibration_done, and the input then holds
// ready low until the new offsets are written: the sample drains through
// the averaging pipeline and the calibration divider takes three more
// steps before the next sample transfer, longer when the output is stalled.
// Apart from that pause, the rate is one sample per cycle while the output
// is not stalled, set by the running sum and the delay line, which both
// advance once per transfer.
// ----------------------------------------------------------------------------
`include "three_axis_offset_moving_average_assert.svh"

module three_axis_offset_moving_average (
  input logic          clk_i,
  input logic          rst_ni,
  tamavg_in_if.sink    in_i,
  tamavg_out_if.source out_o
);
  import tamavg_pkg::*;

  // --------------------------------------------------------------------------
  // Pipeline handshake. Each stage moves forward when the next stage is empty
  // or moving itself, so bubbles close up even while the output is stalled.
  // --------------------------------------------------------------------------
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic go1, go2, go3, go4, go5;
  logic in_fire;
  logic cal_busy_q;
  logic cal_upd;

  assign go5 = v4_q && (!v5_q || out_o.ready);
  assign go4 = v3_q && (!v4_q || go5);
  assign go3 = v2_q && (!v3_q || go4);
  assign go2 = v1_q && (!v2_q || go3);
  assign go1 = v0_q && (!v1_q || go2);

  // No sample is taken while the offsets are being recomputed, since the
  // next sample must see the new offsets.
  assign in_i.ready = (!v0_q || go1) && !cal_busy_q;
  assign in_fire    = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // Stage 0: offset correction and calibration counting.
  // --------------------------------------------------------------------------
  axes_t            raw;
  axes_t            offset;
  axes_t            corr0_q;
  logic             cal0_q, done0_q;
  logic [CNT_W-1:0] cnt_q;
  logic             cnt_last;

  assign raw[0] = in_i.raw_x;
  assign raw[1] = in_i.raw_y;
  assign raw[2] = in_i.raw_z;

  // The calibration count depends only on the calibrate flags, so the sample
  // that completes a calibration is known as soon as it is taken.
  assign cnt_last = (cnt_q == CNT_W'(CAL_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      cal_busy_q <= 1'b0;
    end else begin
      if (in_fire && in_i.calibrate) begin
        cnt_q <= cnt_last ? '0 : cnt_q + CNT_W'(1);
      end
      if (in_fire && in_i.calibrate && cnt_last) begin
        cal_busy_q <= 1'b1;
      end else if (cal_upd) begin
        cal_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int a = 0; a < AXES; a++) begin
        corr0_q[a] <= raw[a] - offset[a];
      end
      cal0_q  <= in_i.calibrate;
      done0_q <= in_i.calibrate && cnt_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: delay line of cells and the running sum. The sum gains the new
  // sample and loses the one that falls off the end of the delay line.
  // --------------------------------------------------------------------------
  axes_t                       tap [FILTER_TAPS+1];
  logic signed [TAP_SUM_W-1:0] sum_q [AXES];
  logic                        cal1_q, done1_q;

  assign tap[0] = corr0_q;

  for (genvar k = 0; k < FILTER_TAPS; k++) begin : g_cell
    tamavg_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(go1),
      .tap_i  (tap[k]),
      .tap_o  (tap[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= '0;
      end
    end else if (go1) begin
      for (int a = 0; a < AXES; a++) begin
        sum_q[a] <= sum_q[a] + TAP_SUM_W'(corr0_q[a])
                    - TAP_SUM_W'(tap[FILTER_TAPS][a]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go1) begin
      cal1_q  <= cal0_q;
      done1_q <= done0_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2 to 4: sum divided by FILTER_TAPS, truncating toward zero. The
  // magnitude is multiplied by a rounded-up reciprocal, which is exact over
  // the whole range of the sum, and the sign is put back afterwards.
  // --------------------------------------------------------------------------
  logic [TAP_MAG_W-1:0]  mag2_q [AXES];
  logic [AXES-1:0]       neg2_q, neg3_q;
  logic [SAMPLE_W-1:0]   quo3_q [AXES];
  logic [TAP_PROD_W-1:0] prod3 [AXES];
  axes_t                 filt4_q;
  logic                  cal2_q, done2_q, cal3_q, done3_q, cal4_q, done4_q;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prod3[a] = TAP_PROD_W'(mag2_q[a]) * TAP_PROD_W'(TAP_RECIP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go2) begin
      for (int a = 0; a < AXES; a++) begin
        neg2_q[a] <= sum_q[a][TAP_SUM_W-1];
        mag2_q[a] <= sum_q[a][TAP_SUM_W-1] ? TAP_MAG_W'(-sum_q[a])
                                           : TAP_MAG_W'(sum_q[a]);
      end
      cal2_q  <= cal1_q;
      done2_q <= done1_q;
    end
    if (go3) begin
      for (int a = 0; a < AXES; a++) begin
        quo3_q[a] <= prod3[a][TAP_DIV_SHIFT +: SAMPLE_W];
      end
      neg3_q  <= neg2_q;
      cal3_q  <= cal2_q;
      done3_q <= done2_q;
    end
    if (go4) begin
      for (int a = 0; a < AXES; a++) begin
        filt4_q[a] <= neg3_q[a] ? -sample_t'(quo3_q[a]) : sample_t'(quo3_q[a]);
      end
      cal4_q  <= cal3_q;
      done4_q <= done3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: output register with the acceleration scaling. The same transfer
  // hands the filtered value to the calibration sums.
  // --------------------------------------------------------------------------
  axes_t    filt5_q;
  accel_t   accel_d [AXES];
  accel_t   accel5_q [AXES];
  logic     done5_q;
  cal_ctl_t cal_ctl;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      accel_d[a] = ACCEL_W'(filt4_q[a]) * ACCEL_W'(G_SCALE_TENTH_MG);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go5) begin
      filt5_q <= filt4_q;
      for (int a = 0; a < AXES; a++) begin
        accel5_q[a] <= accel_d[a];
      end
      done5_q <= done4_q;
    end
  end

  assign cal_ctl.fire = go5;
  assign cal_ctl.cal  = cal4_q;
  assign cal_ctl.done = done4_q;

  tamavg_cal u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cal_ctl),
    .filt_i  (filt4_q),
    .offset_o(offset),
    .upd_o   (cal_upd)
  );

  // --------------------------------------------------------------------------
  // Stage occupancy.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (in_fire) begin
        v0_q <= 1'b1;
      end else if (go1) begin
        v0_q <= 1'b0;
      end
      if (go1) begin
        v1_q <= 1'b1;
      end else if (go2) begin
        v1_q <= 1'b0;
      end
      if (go2) begin
        v2_q <= 1'b1;
      end else if (go3) begin
        v2_q <= 1'b0;
      end
      if (go3) begin
        v3_q <= 1'b1;
      end else if (go4) begin
        v3_q <= 1'b0;
      end
      if (go4) begin
        v4_q <= 1'b1;
      end else if (go5) begin
        v4_q <= 1'b0;
      end
      if (go5) begin
        v5_q <= 1'b1;
      end else if (out_o.ready) begin
        v5_q <= 1'b0;
      end
    end
  end

  assign out_o.valid            = v5_q;
  assign out_o.filtered_x       = filt5_q[0];
  assign out_o.filtered_y       = filt5_q[1];
  assign out_o.filtered_z       = filt5_q[2];
  assign out_o.accel_x          = accel5_q[0];
  assign out_o.accel_y          = accel5_q[1];
  assign out_o.accel_z          = accel5_q[2];
  assign out_o.calibration_done = done5_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  logic [4:0] done_in_flight;

  assign done_in_flight = {v4_q && done4_q, v3_q && done3_q, v2_q && done2_q,
                           v1_q && done1_q, v0_q && done0_q};

  // Offsets may change only during the pause that a completed calibration
  // opens; any other change would corrupt samples already corrected.
  `TAMAVG_ASSERT_NEXT(a_offset_stable_when_idle, !cal_busy_q, $stable(offset), "offset changed outside calibration")
  // The completing sample of one calibration must leave the pipeline before
  // the next calibration can complete.
  `TAMAVG_ASSERT_IMPL(a_one_done_in_flight, 1'b1, $countones(done_in_flight) <= 1, "two calibration completions in flight")
  // The count wraps at the calibration length and never reaches it.
  `TAMAVG_ASSERT_IMPL(a_cnt_in_range, 1'b1, cnt_q < CNT_W'(CAL_COUNT), "calibration count out of range")
  // A completing sample in the pipeline means the input is held off.
  `TAMAVG_ASSERT_IMPL(a_busy_with_done, done_in_flight != '0, cal_busy_q, "calibration completing without input hold-off")

endmodule
